// File: sv/sha256_fixed_32_byte_message_defines.svh
// Assertion macros used by the checker of the hash block.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef SHA256_FIXED_32_BYTE_MESSAGE_DEFINES_SVH
`define SHA256_FIXED_32_BYTE_MESSAGE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define S256F_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define S256F_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/s256f_pkg.sv
package s256f_pkg;

    typedef logic [31:0] t_word;
    typedef t_word t_hash [8];
    typedef t_word t_blk [16];
    typedef logic [5:0] t_rnd;

    // Control from the sequencer to the schedule and round units.
    typedef struct packed {
        logic load;
        logic step;
    } t_ctl;

    localparam t_rnd LAST_RND = 6'd63;

    // Fixed padding of a 256-bit message inside one 512-bit block.
    localparam t_word PAD_WORD = 32'h8000_0000;
    localparam t_word ZERO_WORD = 32'h0000_0000;
    localparam t_word LEN_WORD = 32'd256;

    localparam t_hash INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word ror(input t_word v, input int unsigned amt);
        ror = (v >> amt) | (v << (32 - amt));
    endfunction

    function automatic t_word small_sig0(input t_word x);
        small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sig0(input t_word x);
        big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

// File: sv/s256f_if.sv
interface s256f_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_part0;
    logic [63:0] msg_part1;
    logic [63:0] msg_part2;
    logic [63:0] msg_part3;
    logic        batch_end_in;

    modport source (
        output valid, msg_part0, msg_part1, msg_part2, msg_part3, batch_end_in,
        input  ready
    );
    modport sink (
        input  valid, msg_part0, msg_part1, msg_part2, msg_part3, batch_end_in,
        output ready
    );
endinterface

interface s256f_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;
    logic        batch_end_out;

    modport source (
        output valid, digest_part0, digest_part1, digest_part2, digest_part3,
               batch_end_out,
        input  ready
    );
    modport sink (
        input  valid, digest_part0, digest_part1, digest_part2, digest_part3,
               batch_end_out,
        output ready
    );
endinterface

// File: sv/s256f_sched.sv
module s256f_sched (
    input  logic             i_clk,
    input  s256f_pkg::t_ctl  i_ctl,
    input  s256f_pkg::t_blk  i_blk,
    output s256f_pkg::t_word o_w
);

    // Sliding window of the last sixteen schedule words; entry 0 is the
    // word used by the current round.
    s256f_pkg::t_blk  r_win;
    s256f_pkg::t_word n_new;

    always_comb begin
        n_new = s256f_pkg::small_sig1(r_win[14]) + r_win[9]
              + s256f_pkg::small_sig0(r_win[1]) + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_win <= i_blk;
        end else if (i_ctl.step) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j + 1];
            end
            r_win[15] <= n_new;
        end
    end

    assign o_w = r_win[0];

endmodule

// File: sv/s256f_round.sv
module s256f_round (
    input  logic             i_clk,
    input  s256f_pkg::t_ctl  i_ctl,
    input  s256f_pkg::t_rnd  i_rnd,
    input  s256f_pkg::t_word i_w,
    output s256f_pkg::t_hash o_digest
);

    // Working variables a..h at indices 0..7.
    s256f_pkg::t_hash r_v;
    s256f_pkg::t_word n_t1;
    s256f_pkg::t_word n_t2;
    s256f_pkg::t_word n_ch;
    s256f_pkg::t_word n_maj;

    always_comb begin
        n_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        n_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        n_t1  = r_v[7] + s256f_pkg::big_sig1(r_v[4]) + n_ch
              + s256f_pkg::ROUND_K[i_rnd] + i_w;
        n_t2  = s256f_pkg::big_sig0(r_v[0]) + n_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= s256f_pkg::INIT_HASH;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            o_digest[j] = r_v[j] + s256f_pkg::INIT_HASH[j];
        end
    end

endmodule

// File: sv/sha256_fixed_32_byte_message.sv
// SHA-256 digest of one 32-byte message.
// i_msg carries the message as four big-endian 64-bit parts plus a batch end
// mark; o_dig returns the 256-bit digest as four big-endian parts with the
// mark copied unchanged. Both channels move a beat when valid and ready are
// high at a rising edge of i_clk.
// A beat is taken only while the core is idle. It then runs one compression
// round per cycle, the message schedule window advancing in step, and in its
// final state adds the initial hash back and loads the output register. A new
// message is taken only once the previous one has left the final state.
// The message rate is set by the single round unit, which is reused for all rounds.
// The output register holds a finished digest while the receiver stalls; the
// core still takes and hashes the next message, but waits in its final state
// until the held digest has gone.
// i_rst_n is synchronous and active low; it empties the core and the output
// register. No state survives from one message to the next.
module sha256_fixed_32_byte_message (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s256f_in_if.sink   i_msg,
    s256f_out_if.source o_dig
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    s256f_pkg::t_rnd   r_rnd, n_rnd;
    logic              r_batch;
    logic              r_out_vld, n_out_vld;
    logic [63:0]       r_dig0, r_dig1, r_dig2, r_dig3;
    logic              r_out_be;

    s256f_pkg::t_ctl   ctl;
    s256f_pkg::t_blk   blk;
    s256f_pkg::t_word  w;
    s256f_pkg::t_hash  digest;
    logic              in_acc;
    logic              fin_take;

    assign i_msg.ready = (r_state == ST_IDLE);
    assign in_acc      = i_msg.valid && i_msg.ready;
    assign fin_take    = (r_state == ST_FIN) && (!r_out_vld || o_dig.ready);

    assign ctl.load = in_acc;
    assign ctl.step = (r_state == ST_RUN);

    always_comb begin
        blk[0]  = i_msg.msg_part0[63:32];
        blk[1]  = i_msg.msg_part0[31:0];
        blk[2]  = i_msg.msg_part1[63:32];
        blk[3]  = i_msg.msg_part1[31:0];
        blk[4]  = i_msg.msg_part2[63:32];
        blk[5]  = i_msg.msg_part2[31:0];
        blk[6]  = i_msg.msg_part3[63:32];
        blk[7]  = i_msg.msg_part3[31:0];
        blk[8]  = s256f_pkg::PAD_WORD;
        for (int j = 9; j < 15; j++) begin
            blk[j] = s256f_pkg::ZERO_WORD;
        end
        blk[15] = s256f_pkg::LEN_WORD;
    end

    s256f_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_blk (blk),
        .o_w   (w)
    );

    s256f_round u_round (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_rnd    (r_rnd),
        .i_w      (w),
        .o_digest (digest)
    );

    always_comb begin
        n_state   = r_state;
        n_rnd     = r_rnd;
        n_out_vld = r_out_vld;
        if (r_out_vld && o_dig.ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RUN;
                    n_rnd   = '0;
                end
            end
            ST_RUN: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == s256f_pkg::LAST_RND) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_take) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rnd     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rnd     <= n_rnd;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_batch <= i_msg.batch_end_in;
        end
        if (fin_take) begin
            r_dig0   <= {digest[0], digest[1]};
            r_dig1   <= {digest[2], digest[3]};
            r_dig2   <= {digest[4], digest[5]};
            r_dig3   <= {digest[6], digest[7]};
            r_out_be <= r_batch;
        end
    end

    assign o_dig.valid         = r_out_vld;
    assign o_dig.digest_part0  = r_dig0;
    assign o_dig.digest_part1  = r_dig1;
    assign o_dig.digest_part2  = r_dig2;
    assign o_dig.digest_part3  = r_dig3;
    assign o_dig.batch_end_out = r_out_be;

endmodule

// File: sv/s256f_chk.sv
`include "sha256_fixed_32_byte_message_defines.svh"

module s256f_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_digest0
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // A taken message keeps the core busy for all of its rounds.
    `S256F_ASSERT_NXT(a_busy_after_beat, in_acc, !i_in_ready, "core ready right after a beat")
    `S256F_ASSERT_IMP(a_busy_64, in_acc, ##64 !i_in_ready, "core ready within 64 cycles")

    // A fresh digest only ever appears out of the busy phase.
    `S256F_ASSERT_IMP(a_rise_src, $rose(i_out_valid), $past(!i_in_ready), "digest while idle")

    `S256F_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_digest0), "stalled digest beat changed")

endmodule

bind sha256_fixed_32_byte_message s256f_chk u_s256f_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_msg.valid),
    .i_in_ready  (i_msg.ready),
    .i_out_valid (o_dig.valid),
    .i_out_ready (o_dig.ready),
    .i_digest0   (o_dig.digest_part0)
);

// File: tb/sv/tb.sv
module tb;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 80;

    // Idle behaviour of either side of the block.
    typedef enum int { IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY } idle_mode_t;

    typedef struct packed {
        logic [63:0] part0;
        logic [63:0] part1;
        logic [63:0] part2;
        logic [63:0] part3;
        logic        batch_end;
    } msg_t;

    typedef struct packed {
        logic [63:0] part0;
        logic [63:0] part1;
        logic [63:0] part2;
        logic [63:0] part3;
        logic        batch_end;
    } digest_t;

    localparam logic [31:0] BLOCK_PAD = 32'h8000_0000;
    localparam logic [31:0] MSG_BITS = 32'd256;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic clk;
    logic rst_n;

    s256f_in_if  msg_if ();
    s256f_out_if dig_if ();

    sha256_fixed_32_byte_message i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_msg   (msg_if),
        .o_dig   (dig_if)
    );

    digest_t     pending_digests [$];
    idle_mode_t  tx_mode;
    idle_mode_t  rx_mode;
    int unsigned cycle_count;
    int unsigned msgs_sent;
    int unsigned digests_seen;
    int unsigned error_count;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Single padded block: message words, the pad word, zeros, then the
    // bit length of the message.
    function automatic digest_t hash_message(input msg_t m);
        logic [31:0]  w [64];
        logic [31:0]  v [8];
        logic [255:0] words;
        logic [31:0]  s0;
        logic [31:0]  s1;
        logic [31:0]  t1;
        logic [31:0]  t2;
        digest_t      d;
        words = {m.part0, m.part1, m.part2, m.part3};
        for (int i = 0; i < 8; i++) begin
            w[i] = words[255 - 32 * i -: 32];
        end
        w[8] = BLOCK_PAD;
        for (int i = 9; i < 15; i++) begin
            w[i] = '0;
        end
        w[15] = MSG_BITS;
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = HASH_IV[i];
        end
        for (int i = 0; i < 64; i++) begin
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_CONST[i] + w[i];
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = v[i] + HASH_IV[i];
        end
        d.part0 = {v[0], v[1]};
        d.part1 = {v[2], v[3]};
        d.part2 = {v[4], v[5]};
        d.part3 = {v[6], v[7]};
        d.batch_end = m.batch_end;
        return d;
    endfunction

    function automatic int unsigned pick_gap(input idle_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            IDLE_LIGHT: begin
                if (r < 70) return 0;
                if (r < 95) return $urandom_range(1, 3);
                return $urandom_range(10, 60);
            end
            IDLE_HEAVY: begin
                if (r < 30) return 0;
                if (r < 80) return $urandom_range(1, 8);
                return $urandom_range(20, 120);
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic idle_mode_t pick_mode();
        case ($urandom_range(0, 2))
            0: return IDLE_NONE;
            1: return IDLE_LIGHT;
            default: return IDLE_HEAVY;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch on digest %0d, %s: got %h, expected %h",
                 digests_seen, what, got, want);
    endtask

    // Sends one message beat; the data lines carry noise while valid is low.
    task automatic send_msg(input logic [63:0] p0, input logic [63:0] p1,
                            input logic [63:0] p2, input logic [63:0] p3,
                            input logic last);
        int unsigned gap;
        msg_t        m;
        gap = pick_gap(tx_mode);
        m = '{part0: p0, part1: p1, part2: p2, part3: p3, batch_end: last};
        @(negedge clk);
        if (gap > 0) begin
            msg_if.valid = 1'b0;
            repeat (gap) begin
                msg_if.msg_part0    = rand64();
                msg_if.msg_part1    = rand64();
                msg_if.msg_part2    = rand64();
                msg_if.msg_part3    = rand64();
                msg_if.batch_end_in = $urandom_range(0, 1);
                @(negedge clk);
            end
        end
        msg_if.valid        = 1'b1;
        msg_if.msg_part0    = m.part0;
        msg_if.msg_part1    = m.part1;
        msg_if.msg_part2    = m.part2;
        msg_if.msg_part3    = m.part3;
        msg_if.batch_end_in = m.batch_end;
        do begin
            @(posedge clk);
        end while (msg_if.ready !== 1'b1);
        pending_digests.push_back(hash_message(m));
        msgs_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) begin
            send_msg(rand64(), rand64(), rand64(), rand64(), $urandom_range(0, 1));
        end
    endtask

    task automatic test_directed();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        send_msg('0, '0, '0, '0, 1'b0);
        send_msg('1, '1, '1, '1, 1'b1);
        send_msg({4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}}, 1'b0);
        send_msg({4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}}, 1'b1);
        send_msg(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                 64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f, 1'b1);
        // A single set bit at the top and at the bottom of each part.
        for (int k = 0; k < 4; k++) begin
            send_msg(k == 0 ? 64'h8000_0000_0000_0000 : '0,
                     k == 1 ? 64'h8000_0000_0000_0000 : '0,
                     k == 2 ? 64'h8000_0000_0000_0000 : '0,
                     k == 3 ? 64'h8000_0000_0000_0000 : '0, k[0]);
            send_msg(k == 0 ? 64'h1 : '0, k == 1 ? 64'h1 : '0,
                     k == 2 ? 64'h1 : '0, k == 3 ? 64'h1 : '0, ~k[0]);
        end
        // A message that looks like padding itself, then alternating all-ones and zero parts.
        send_msg({BLOCK_PAD, 32'h0}, '0, '0, {32'h0, MSG_BITS}, 1'b0);
        send_msg('1, '0, '1, '0, 1'b1);
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_HEAVY;
        send_msg('0, '1, '0, '1, 1'b0);
        send_msg(64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff,
                 64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff, 1'b1);
        send_msg('0, '0, '0, '0, 1'b1);
        send_msg('1, '1, '1, '1, 1'b0);
    endtask

    task automatic test_back_to_back();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        send_random(150);
    endtask

    // The receiver stalls hard, so digests are held while the next
    // message is already being hashed.
    task automatic test_output_stall();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_HEAVY;
        send_random(150);
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 13; blk++) begin
            tx_mode = pick_mode();
            rx_mode = pick_mode();
            send_random(50);
        end
    endtask

    // Sparse, dense, repeated-byte and single-bit patterns stress the carries in the adders.
    task automatic test_bit_density();
        logic [63:0] p [4];
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_LIGHT;
        repeat (100) begin
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 3))
                    0: p[k] = rand64() & rand64() & rand64() & rand64();
                    1: p[k] = rand64() | rand64() | rand64() | rand64();
                    2: p[k] = {8{8'($urandom)}};
                    default: p[k] = 64'h1 << $urandom_range(0, 63);
                endcase
            end
            send_msg(p[0], p[1], p[2], p[3], $urandom_range(0, 1));
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit with %0d digests outstanding",
                 pending_digests.size());
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: ready drops for stretches chosen by the current idle mode.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        dig_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                dig_if.ready = 1'b0;
                stall_left--;
            end else begin
                dig_if.ready = 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap(rx_mode);
                end
            end
        end
    end

    always @(posedge clk) begin
        digest_t want;
        if (rst_n && dig_if.valid === 1'b1 && dig_if.ready === 1'b1) begin
            digests_seen++;
            if (pending_digests.size() == 0) begin
                error_count++;
                $display("digest %0d arrived with no message outstanding", digests_seen);
            end else begin
                want = pending_digests.pop_front();
                if (dig_if.digest_part0 !== want.part0)
                    report_mismatch("digest_part0", dig_if.digest_part0, want.part0);
                if (dig_if.digest_part1 !== want.part1)
                    report_mismatch("digest_part1", dig_if.digest_part1, want.part1);
                if (dig_if.digest_part2 !== want.part2)
                    report_mismatch("digest_part2", dig_if.digest_part2, want.part2);
                if (dig_if.digest_part3 !== want.part3)
                    report_mismatch("digest_part3", dig_if.digest_part3, want.part3);
                if (dig_if.batch_end_out !== want.batch_end)
                    report_mismatch("batch_end_out", 64'(dig_if.batch_end_out),
                                    64'(want.batch_end));
            end
        end
    end

    initial begin
        cycle_count  = 0;
        msgs_sent    = 0;
        digests_seen = 0;
        error_count  = 0;
        tx_mode      = IDLE_NONE;
        rx_mode      = IDLE_NONE;
        msg_if.valid        = 1'b0;
        msg_if.msg_part0    = '0;
        msg_if.msg_part1    = '0;
        msg_if.msg_part2    = '0;
        msg_if.msg_part3    = '0;
        msg_if.batch_end_in = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_output_stall();
        test_random_mix();
        test_bit_density();

        @(negedge clk);
        msg_if.valid = 1'b0;
        rx_mode = IDLE_LIGHT;
        while (pending_digests.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d messages hashed and %0d digests compared in %0d cycles,",
                 msgs_sent, digests_seen, cycle_count);
        $display("covering fixed patterns, back-to-back beats, output stalls and random idling.");
        if (error_count == 0 && pending_digests.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sha256_fixed_32_byte_message.f
+incdir+sv
sv/s256f_pkg.sv
sv/s256f_if.sv
sv/s256f_sched.sv
sv/s256f_round.sv
sv/sha256_fixed_32_byte_message.sv
sv/s256f_chk.sv
tb/sv/tb.sv
